/* rtl/complex_fir_filter_macros.svh */
// Assertion macros for the complex FIR filter.
// Expects clk and arst_n in the scope of each use.
`ifndef COMPLEX_FIR_FILTER_MACROS_SVH
`define COMPLEX_FIR_FILTER_MACROS_SVH
`ifndef SYNTH
`define CFIR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CFIR_ASSERT(lbl, prop, msg)
`define CFIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/cfir_pkg.sv */
// Shared constants and types of the complex FIR filter.
// No dependencies.
`default_nettype none
package cfir_pkg;
	localparam int TAPS      = 8;
	localparam int NCOEF     = 8;
	localparam int SMP_W     = 16;
	localparam int COEF_W    = 16;
	localparam int CFG_W     = 2 * COEF_W;
	localparam int CFG_IDX_W = 4;
	localparam int CIDX_W    = $clog2(NCOEF);
	localparam int PROD_W    = SMP_W + COEF_W;
	localparam int TERM_W    = PROD_W + 1;
	localparam int OUT_W     = 36;
	localparam int LVLS      = $clog2(TAPS);
	localparam int NPAD      = 1 << LVLS;
	localparam int PIPE      = 3 + LVLS;
	localparam logic [CFG_W-1:0] COEF0_RST = 32'h0800_0000;

	typedef struct packed {
		logic load;
		logic clr;
		logic adv_s2;
		logic adv_s3;
	} cfir_cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/cfir_ifs.sv */
// Channel interfaces: sample input, result output, coefficient writes.
// Depends on cfir_pkg.
`default_nettype none
interface cfir_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [cfir_pkg::SMP_W-1:0]   sample_re;
	logic signed [cfir_pkg::SMP_W-1:0]   sample_im;
	logic                                first;
	modport source(output valid, sample_re, sample_im, first, input ready);
	modport sink(input valid, sample_re, sample_im, first, output ready);
endinterface

interface cfir_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cfir_pkg::OUT_W-1:0]   out_re;
	logic signed [cfir_pkg::OUT_W-1:0]   out_im;
	modport source(output valid, out_re, out_im, input ready);
	modport sink(input valid, out_re, out_im, output ready);
endinterface

interface cfir_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [cfir_pkg::CFG_IDX_W-1:0]      index;
	logic [cfir_pkg::CFG_W-1:0]          data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/cfir_cell.sv */
// One tap cell: delay register, complex multiply, product combine.
// Depends on cfir_pkg and complex_fir_filter_macros.svh.
`default_nettype none
`include "complex_fir_filter_macros.svh"
module cfir_cell (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire cfir_pkg::cfir_cell_ctl_t        ctl,
	input  wire [cfir_pkg::CFG_W-1:0]            coef,
	input  wire signed [cfir_pkg::SMP_W-1:0]     x_re,
	input  wire signed [cfir_pkg::SMP_W-1:0]     x_im,
	output logic signed [cfir_pkg::SMP_W-1:0]    smp_re,
	output logic signed [cfir_pkg::SMP_W-1:0]    smp_im,
	output logic signed [cfir_pkg::TERM_W-1:0]   term_re,
	output logic signed [cfir_pkg::TERM_W-1:0]   term_im
);
	import cfir_pkg::*;

	logic signed [SMP_W-1:0]  smp_re_q, smp_im_q;
	logic signed [COEF_W-1:0] c_re, c_im;
	logic signed [PROD_W-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [TERM_W-1:0] term_re_s3, term_im_s3;

	assign c_re = signed'(coef[CFG_W-1:COEF_W]);
	assign c_im = signed'(coef[COEF_W-1:0]);

	// delay line entry, shifts only on a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_re_q <= '0;
			smp_im_q <= '0;
		end else if (ctl.load) begin
			smp_re_q <= ctl.clr ? '0 : x_re;
			smp_im_q <= ctl.clr ? '0 : x_im;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			p_rr_s2 <= smp_re_q * c_re;
			p_ii_s2 <= smp_im_q * c_im;
			p_ri_s2 <= smp_re_q * c_im;
			p_ir_s2 <= smp_im_q * c_re;
		end
		if (ctl.adv_s3) begin
			term_re_s3 <= TERM_W'(p_rr_s2) - TERM_W'(p_ii_s2);
			term_im_s3 <= TERM_W'(p_ri_s2) + TERM_W'(p_ir_s2);
		end
	end

	assign smp_re  = smp_re_q;
	assign smp_im  = smp_im_q;
	assign term_re = term_re_s3;
	assign term_im = term_im_s3;

	`CFIR_ASSERT_NEXT(a_clr_zero, ctl.load && ctl.clr, (smp_re_q == '0) && (smp_im_q == '0), "history not cleared")
	`CFIR_ASSERT_NEXT(a_hold, !ctl.load, $stable(smp_re_q) && $stable(smp_im_q), "history moved without request")
endmodule
`default_nettype wire

/* rtl/cfir_tree.sv */
// Registered adder tree summing the tap terms, one level per stage.
// Depends on cfir_pkg.
`default_nettype none
module cfir_tree (
	input  wire                                  clk,
	input  wire [cfir_pkg::PIPE-1:0]             adv,
	input  wire signed [cfir_pkg::TERM_W-1:0]    term_re [cfir_pkg::TAPS],
	input  wire signed [cfir_pkg::TERM_W-1:0]    term_im [cfir_pkg::TAPS],
	output logic signed [cfir_pkg::OUT_W-1:0]    sum_re,
	output logic signed [cfir_pkg::OUT_W-1:0]    sum_im
);
	import cfir_pkg::*;

	logic signed [OUT_W-1:0] leaf_re [NPAD];
	logic signed [OUT_W-1:0] leaf_im [NPAD];
	logic signed [OUT_W-1:0] node_re_q [NPAD];
	logic signed [OUT_W-1:0] node_im_q [NPAD];

	for (genvar j = 0; j < NPAD; j++) begin : g_leaf
		if (j < TAPS) begin : g_used
			assign leaf_re[j] = OUT_W'(term_re[j]);
			assign leaf_im[j] = OUT_W'(term_im[j]);
		end else begin : g_pad
			assign leaf_re[j] = '0;
			assign leaf_im[j] = '0;
		end
	end

	// heap order: node n adds children 2n and 2n+1
	for (genvar n = 1; n < NPAD; n++) begin : g_node
		localparam int D  = $clog2(n + 1) - 1;
		localparam int ST = 2 + LVLS - D;
		logic signed [OUT_W-1:0] a_re, b_re, a_im, b_im;
		if (2 * n >= NPAD) begin : g_from_leaf
			assign a_re = leaf_re[2 * n - NPAD];
			assign b_re = leaf_re[2 * n + 1 - NPAD];
			assign a_im = leaf_im[2 * n - NPAD];
			assign b_im = leaf_im[2 * n + 1 - NPAD];
		end else begin : g_from_node
			assign a_re = node_re_q[2 * n];
			assign b_re = node_re_q[2 * n + 1];
			assign a_im = node_im_q[2 * n];
			assign b_im = node_im_q[2 * n + 1];
		end
		always_ff @(posedge clk) begin
			if (adv[ST]) begin
				node_re_q[n] <= a_re + b_re;
				node_im_q[n] <= a_im + b_im;
			end
		end
	end

	if (NPAD == 1) begin : g_root_leaf
		assign sum_re = leaf_re[0];
		assign sum_im = leaf_im[0];
	end else begin : g_root_node
		assign sum_re = node_re_q[1];
		assign sum_im = node_im_q[1];
	end
endmodule
`default_nettype wire

/* rtl/complex_fir_filter.sv */
// Complex FIR filter top: coefficient bank, cell chain, adder tree, stage control.
// Depends on cfir_pkg, cfir_ifs, cfir_cell, cfir_tree, complex_fir_filter_macros.svh.
//
// Takes one complex Q3.12 sample per clock while no stage stalls, and returns one
// exact 36-bit complex sum (23 fractional bits) per sample, in order. Stages, in
// order: delay-line load, multiply, term combine, then one adder-tree level per
// stage. Each stage moves on when it is empty or its successor moves, so bubbles
// close up and input is taken while a result waits, as long as a stage is free.
// smp.ready depends combinationally on res.ready through that chain. A set first
// flag zeroes the delay line under the new sample. Coefficient writes are always
// accepted; indexes past the last tap are dropped.
`default_nettype none
`include "complex_fir_filter_macros.svh"
module complex_fir_filter (
	input  wire          clk,
	input  wire          arst_n,
	cfir_in_if.sink      smp,
	cfir_out_if.source   res,
	cfir_cfg_if.sink     cfg
);
	import cfir_pkg::*;

	logic [CFG_W-1:0]         coef_q [NCOEF];
	logic [PIPE-1:0]          vld_q;
	logic [PIPE-1:0]          adv;
	logic                     accept;
	logic signed [SMP_W-1:0]  smp_re [TAPS];
	logic signed [SMP_W-1:0]  smp_im [TAPS];
	logic signed [TERM_W-1:0] term_re [TAPS];
	logic signed [TERM_W-1:0] term_im [TAPS];
	logic signed [OUT_W-1:0]  sum_re, sum_im;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NCOEF; k++) begin
				coef_q[k] <= (k == 0) ? COEF0_RST : '0;
			end
		end else if (cfg.valid && (cfg.index < CFG_IDX_W'(NCOEF))) begin
			coef_q[cfg.index[CIDX_W-1:0]] <= cfg.data;
		end
	end

	assign adv[PIPE-1] = !vld_q[PIPE-1] || res.ready;
	for (genvar k = 0; k < PIPE - 1; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k + 1];
	end

	assign smp.ready = adv[0];
	assign accept    = smp.valid && adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= smp.valid;
			end
			for (int k = 1; k < PIPE; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		cfir_cell_ctl_t          ctl;
		logic signed [SMP_W-1:0] x_re, x_im;

		assign ctl.load   = accept;
		assign ctl.clr    = (k != 0) && smp.first;
		assign ctl.adv_s2 = adv[1];
		assign ctl.adv_s3 = adv[2];

		if (k == 0) begin : g_head
			assign x_re = smp.sample_re;
			assign x_im = smp.sample_im;
		end else begin : g_link
			assign x_re = smp_re[k - 1];
			assign x_im = smp_im[k - 1];
		end

		cfir_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.coef    (coef_q[k]),
			.x_re    (x_re),
			.x_im    (x_im),
			.smp_re  (smp_re[k]),
			.smp_im  (smp_im[k]),
			.term_re (term_re[k]),
			.term_im (term_im[k])
		);
	end

	cfir_tree u_tree (
		.clk     (clk),
		.adv     (adv),
		.term_re (term_re),
		.term_im (term_im),
		.sum_re  (sum_re),
		.sum_im  (sum_im)
	);

	assign res.valid  = vld_q[PIPE-1];
	assign res.out_re = sum_re;
	assign res.out_im = sum_im;

	`CFIR_ASSERT(a_ready_when_drained, !vld_q[PIPE-1] |-> smp.ready, "stall with empty output stage")
	`CFIR_ASSERT_NEXT(a_accept_fills, accept, vld_q[0], "request lost at entry stage")
	`CFIR_ASSERT(a_stall_means_full, !smp.ready |-> vld_q[0], "stall with empty entry stage")
endmodule
`default_nettype wire
